### hw/rtl/recent_name_dedup_filter_assert.svh
// assertion macros used by rndf_dp
`ifndef RECENT_NAME_DEDUP_FILTER_ASSERT_SVH
`define RECENT_NAME_DEDUP_FILTER_ASSERT_SVH

// property checked on every rising edge outside reset
`define RNDF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the cycle after
`define RNDF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/rndf_pkg.sv
package rndf_pkg;

    localparam logic [7:0] DOT_CHAR = 8'h2E;
    localparam int         SLOT_W   = 9;

    typedef struct packed {
        logic [7:0] name_byte;
        logic       name_last;
    } in_word_t;

    typedef struct packed {
        logic              is_new;
        logic [SLOT_W-1:0] slot;
        logic              truncated;
    } out_word_t;

    typedef struct packed {
        logic take;
        logic fin;
        logic len_rd;
        logic byte_rd;
        logic next_entry;
        logic next_byte;
        logic cp_rd;
        logic cp_wr;
        logic hit;
        logic miss;
    } cmd_t;

    typedef struct packed {
        logic i_end;
        logic len_eq;
        logic byte_eq;
        logic j_last;
        logic len_zero;
    } stat_t;

endpackage

### hw/rtl/recent_name_dedup_filter.sv
// recent name duplicate filter
// input: one name byte per word on item, taken when start is high and busy low;
//   item.name_last marks the final byte of a name, a zero byte ends it early
//   and bytes after it are dropped until the flagged byte
// output: one word per name on result, marked by a one-cycle done strobe;
//   is_new says the name was written into the ring, slot where it lives,
//   truncated that it was cut to NAME_BYTES bytes (one trailing dot removed first)
// sequence: a non-final byte leaves busy low; after the final byte busy stays
//   high for the ring walk: a setup step, then per valid entry a length read
//   and check plus a byte read and compare for each byte compared, then a hit
//   step on a hit, or on a miss a step to end the walk, a byte read and a byte
//   write per name byte to copy and a length write
// result: done is high in the first cycle with busy low; the next byte may be
//   given in that same cycle
// the receiver cannot stall, every result word is taken as it appears
// reset: ring empty, write pointer zero, no name in progress; no clearing
//   pass is needed, entries are valid only below the fill count
module recent_name_dedup_filter
#(
    parameter int ENTRIES    = 512,
    parameter int NAME_BYTES = 256
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  rndf_pkg::in_word_t  item,
    output logic                done,
    output rndf_pkg::out_word_t result
);
    import rndf_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    rndf_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .name_last (item.name_last),
        .stat      (stat),
        .cmd       (cmd),
        .busy      (busy)
    );

    rndf_dp
    #(
        .ENTRIES    (ENTRIES),
        .NAME_BYTES (NAME_BYTES)
    )
    u_dp
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .done   (done),
        .result (result)
    );

endmodule

### hw/rtl/rndf_ctrl.sv
module rndf_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          name_last,
    input  rndf_pkg::stat_t stat,
    output rndf_pkg::cmd_t  cmd,
    output logic          busy
);
    import rndf_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_FIN  = 10'b0000000010,
        S_SCAN = 10'b0000000100,
        S_LCHK = 10'b0000001000,
        S_BRD  = 10'b0000010000,
        S_BCHK = 10'b0000100000,
        S_HIT  = 10'b0001000000,
        S_CPRD = 10'b0010000000,
        S_CPWR = 10'b0100000000,
        S_WLEN = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.take = 1'b1;
                    if (name_last)
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_FIN:
            begin
                cmd.fin    = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                // no valid entry left: store the name
                if (stat.i_end)
                begin
                    state_next = stat.len_zero ? S_WLEN : S_CPRD;
                end
                else
                begin
                    cmd.len_rd = 1'b1;
                    state_next = S_LCHK;
                end
            end
            S_LCHK:
            begin
                if (stat.len_eq)
                begin
                    state_next = stat.len_zero ? S_HIT : S_BRD;
                end
                else
                begin
                    cmd.next_entry = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_BRD:
            begin
                cmd.byte_rd = 1'b1;
                state_next  = S_BCHK;
            end
            S_BCHK:
            begin
                if (!stat.byte_eq)
                begin
                    cmd.next_entry = 1'b1;
                    state_next     = S_SCAN;
                end
                else if (stat.j_last)
                begin
                    state_next = S_HIT;
                end
                else
                begin
                    cmd.next_byte = 1'b1;
                    state_next    = S_BRD;
                end
            end
            S_HIT:
            begin
                cmd.hit    = 1'b1;
                state_next = S_IDLE;
            end
            S_CPRD:
            begin
                cmd.cp_rd  = 1'b1;
                state_next = S_CPWR;
            end
            S_CPWR:
            begin
                cmd.cp_wr = 1'b1;
                if (stat.j_last)
                begin
                    state_next = S_WLEN;
                end
                else
                begin
                    cmd.next_byte = 1'b1;
                    state_next    = S_CPRD;
                end
            end
            S_WLEN:
            begin
                cmd.miss   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

### hw/rtl/rndf_dp.sv
`include "recent_name_dedup_filter_assert.svh"

module rndf_dp
#(
    parameter int ENTRIES    = 512,
    parameter int NAME_BYTES = 256
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  rndf_pkg::in_word_t item,
    input  rndf_pkg::cmd_t     cmd,
    output rndf_pkg::stat_t    stat,
    output logic               done,
    output rndf_pkg::out_word_t result
);
    import rndf_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam int JW = $clog2(NAME_BYTES);
    localparam int LW = $clog2(NAME_BYTES + 1);
    localparam int SW = $clog2(NAME_BYTES + 3);

    // staging control
    logic [SW-1:0] cnt_reg, cnt_next;
    logic          ended_reg, ended_next;
    logic [7:0]    held_reg, held_next;
    logic          stg_we;

    // search and ring control
    logic [LW-1:0] len_reg, len_next;
    logic          cut_reg, cut_next;
    logic [IW:0]   i_reg, i_next;
    logic [JW-1:0] j_reg, j_next;
    logic [IW-1:0] wp_reg, wp_next;
    logic [IW:0]   fill_reg, fill_next;

    logic          done_reg;
    out_word_t     res_reg;

    logic [SW-1:0] trim;
    logic          dot;
    logic [IW+SLOT_W-1:0] i_ext, wp_ext;

    // memories
    logic [7:0]    stg_mem [NAME_BYTES];
    logic [7:0]    ent_mem [ENTRIES * (2 ** JW)];
    logic [LW-1:0] len_mem [ENTRIES];
    logic [7:0]    stg_q, ent_q;
    logic [LW-1:0] len_q;

    assign dot  = (cnt_reg != '0) && (held_reg == DOT_CHAR);
    assign trim = cnt_reg - SW'(dot);

    always_comb
    begin
        cnt_next   = cnt_reg;
        ended_next = ended_reg;
        held_next  = held_reg;
        stg_we     = 1'b0;
        len_next   = len_reg;
        cut_next   = cut_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        wp_next    = wp_reg;
        fill_next  = fill_reg;

        if (cmd.take && !ended_reg)
        begin
            if (item.name_byte == 8'd0)
            begin
                ended_next = 1'b1;
            end
            else
            begin
                stg_we = (cnt_reg < SW'(NAME_BYTES));
                if (cnt_reg < SW'(NAME_BYTES + 2))
                begin
                    cnt_next = cnt_reg + SW'(1);
                end
                held_next = item.name_byte;
            end
        end

        if (cmd.fin)
        begin
            cut_next = (trim > SW'(NAME_BYTES));
            len_next = (trim > SW'(NAME_BYTES)) ? LW'(NAME_BYTES) : trim[LW-1:0];
            i_next   = '0;
            j_next   = '0;
        end

        if (cmd.next_entry)
        begin
            i_next = i_reg + (IW+1)'(1);
            j_next = '0;
        end

        if (cmd.next_byte)
        begin
            j_next = j_reg + JW'(1);
        end

        if (cmd.miss)
        begin
            wp_next = (wp_reg == IW'(ENTRIES - 1)) ? '0 : wp_reg + IW'(1);
            if (fill_reg != (IW+1)'(ENTRIES))
            begin
                fill_next = fill_reg + (IW+1)'(1);
            end
        end

        if (cmd.hit || cmd.miss)
        begin
            cnt_next   = '0;
            ended_next = 1'b0;
            held_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            ended_reg <= 1'b0;
            held_reg  <= '0;
            len_reg   <= '0;
            cut_reg   <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
            wp_reg    <= '0;
            fill_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            ended_reg <= ended_next;
            held_reg  <= held_next;
            len_reg   <= len_next;
            cut_reg   <= cut_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            wp_reg    <= wp_next;
            fill_reg  <= fill_next;
            done_reg  <= cmd.hit || cmd.miss;
        end
    end

    assign i_ext  = {{SLOT_W{1'b0}}, i_reg[IW-1:0]};
    assign wp_ext = {{SLOT_W{1'b0}}, wp_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.hit)
        begin
            res_reg.is_new    <= 1'b0;
            res_reg.slot      <= i_ext[SLOT_W-1:0];
            res_reg.truncated <= cut_reg;
        end
        else if (cmd.miss)
        begin
            res_reg.is_new    <= 1'b1;
            res_reg.slot      <= wp_ext[SLOT_W-1:0];
            res_reg.truncated <= cut_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_we)
        begin
            stg_mem[cnt_reg[JW-1:0]] <= item.name_byte;
        end
        if (cmd.byte_rd || cmd.cp_rd)
        begin
            stg_q <= stg_mem[j_reg];
        end
    end

    // one row per slot, rows padded to a power of two
    always_ff @(posedge clk)
    begin
        if (cmd.cp_wr)
        begin
            ent_mem[{wp_reg, j_reg}] <= stg_q;
        end
        if (cmd.byte_rd)
        begin
            ent_q <= ent_mem[{i_reg[IW-1:0], j_reg}];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.miss)
        begin
            len_mem[wp_reg] <= len_reg;
        end
        if (cmd.len_rd)
        begin
            len_q <= len_mem[i_reg[IW-1:0]];
        end
    end

    assign stat.i_end    = (i_reg == fill_reg);
    assign stat.len_eq   = (len_q == len_reg);
    assign stat.byte_eq  = (stg_q == ent_q);
    assign stat.j_last   = ((LW'(j_reg) + LW'(1)) == len_reg);
    assign stat.len_zero = (len_reg == '0);

    assign done   = done_reg;
    assign result = res_reg;

    `RNDF_ASSERT_NEXT(a_done_src, clk, rst_n, cmd.hit || cmd.miss, done_reg, "result word lost")
    `RNDF_ASSERT(a_scan_bound, clk, rst_n, i_reg <= fill_reg, "scan index past valid entries")
    `RNDF_ASSERT(a_copy_len, clk, rst_n, !(cmd.cp_wr && stat.len_zero), "copy of an empty name")

endmodule
